>>> design/rgbhsv_pkg.sv
// Shared constants, word types and sector codes for the RGB to HSV pixel core.
// No dependencies; every other file imports this package.
package rgbhsv_pkg;

   localparam int COMP_BITS  = 8;
   localparam int HUE_BITS   = 16;

   // Number of divider stages; each stage retires HUE_STEP hue and SAT_STEP saturation quotient bits.
   localparam int DIV_STAGES = 8;
   localparam int HUE_STEP   = (HUE_BITS + DIV_STAGES - 1) / DIV_STAGES;
   localparam int SAT_STEP   = (COMP_BITS + DIV_STAGES - 1) / DIV_STAGES;
   localparam int HQ_BITS    = HUE_STEP * DIV_STAGES;
   localparam int SQ_BITS    = SAT_STEP * DIV_STAGES;

   // Hue divisor is 6*delta, always below 2^(COMP_BITS+3).
   localparam int HREM_BITS  = COMP_BITS + 3;
   // Saturation remainder stays below max * 2^SQ_BITS.
   localparam int SAT_W      = COMP_BITS + SQ_BITS;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      logic [COMP_BITS-1:0] value;
      logic [COMP_BITS-1:0] delta;
      sector_type           sector;
      logic [COMP_BITS:0]   diff;      // signed
   } range_word_type;

   typedef struct packed {
      logic                 grey;
      logic [COMP_BITS-1:0] value;
      logic [HREM_BITS-1:0] hue_div;
      logic [HREM_BITS-1:0] hue_rem;
      logic [HQ_BITS-1:0]   hue_q;
      logic [SAT_W-1:0]     sat_div;
      logic [SAT_W-1:0]     sat_rem;
      logic [SQ_BITS-1:0]   sat_q;
   } div_word_type;

endpackage

>>> design/rgb_to_hsv_pixel_core.sv
// RGB to HSV pixel core: two setup stages, then DIV_STAGES divider stages (10 total).
// Each pixel passes through 2 + DIV_STAGES register stages from the req accept to rsp_valid.
// Throughput one pixel per cycle while rsp_ready stays high, set by the fully pipelined
// hue and saturation dividers; bubbles collapse under stalls.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Depends on rgbhsv_pkg, rgbhsv_prep and rgbhsv_div_stage.
module rgb_to_hsv_pixel_core
   import rgbhsv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COMP_BITS-1:0] req_red_in,
   input  logic [COMP_BITS-1:0] req_green_in,
   input  logic [COMP_BITS-1:0] req_blue_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [HUE_BITS-1:0]  rsp_hue_out,
   output logic [COMP_BITS-1:0] rsp_sat_out,
   output logic [COMP_BITS-1:0] rsp_value_out
);

   logic         stage_valid [DIV_STAGES+1];
   logic         stage_ready [DIV_STAGES+1];
   div_word_type stage_word  [DIV_STAGES+1];

   rgbhsv_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .up_red     (req_red_in),
      .up_green   (req_green_in),
      .up_blue    (req_blue_in),
      .down_valid (stage_valid[0]),
      .down_ready (stage_ready[0]),
      .down_word  (stage_word[0])
   );

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      rgbhsv_div_stage u_div (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (stage_valid[i]),
         .up_ready   (stage_ready[i]),
         .up_word    (stage_word[i]),
         .down_valid (stage_valid[i+1]),
         .down_ready (stage_ready[i+1]),
         .down_word  (stage_word[i+1])
      );
   end

   assign stage_ready[DIV_STAGES] = rsp_ready;
   assign rsp_valid               = stage_valid[DIV_STAGES];

   // grey pixels run through the divider with a zero hue divisor; force zero here
   assign rsp_hue_out   = stage_word[DIV_STAGES].grey ? '0 :
                          stage_word[DIV_STAGES].hue_q[HQ_BITS-1 -: HUE_BITS];
   assign rsp_sat_out   = stage_word[DIV_STAGES].grey ? '0 :
                          stage_word[DIV_STAGES].sat_q[COMP_BITS-1:0];
   assign rsp_value_out = stage_word[DIV_STAGES].value;

endmodule

>>> design/rgbhsv_prep.sv
// Front two stages: max/min/sector, then divider operand setup.
// Depends on rgbhsv_pkg.
module rgbhsv_prep
   import rgbhsv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  logic [COMP_BITS-1:0] up_red,
   input  logic [COMP_BITS-1:0] up_green,
   input  logic [COMP_BITS-1:0] up_blue,
   output logic                 down_valid,
   input  logic                 down_ready,
   output div_word_type         down_word
);

   logic           a_valid_ff;
   logic           a_ready;
   range_word_type a_word_ff;
   range_word_type a_word_in;

   logic           b_valid_ff;
   div_word_type   b_word_ff;
   div_word_type   b_word_in;

   logic [COMP_BITS-1:0]   mx;
   logic [COMP_BITS-1:0]   mn;
   logic [COMP_BITS+1:0]   base;
   logic [COMP_BITS+3:0]   x;
   logic [HREM_BITS-1:0]   six_d;
   logic [HREM_BITS-1:0]   x_wrap;
   logic [2*COMP_BITS-1:0] sat_num;

   // stage A: range and sector
   always_comb begin
      mx = up_red;
      mn = up_red;
      if (up_green > mx) mx = up_green;
      if (up_blue > mx) mx = up_blue;
      if (up_green < mn) mn = up_green;
      if (up_blue < mn) mn = up_blue;
      a_word_in.value = mx;
      a_word_in.delta = mx - mn;
      if (up_red == mx) begin
         a_word_in.sector = SECT_RED;
         a_word_in.diff   = {1'b0, up_green} - {1'b0, up_blue};
      end else if (up_green == mx) begin
         a_word_in.sector = SECT_GREEN;
         a_word_in.diff   = {1'b0, up_blue} - {1'b0, up_red};
      end else begin
         a_word_in.sector = SECT_BLUE;
         a_word_in.diff   = {1'b0, up_red} - {1'b0, up_green};
      end
   end

   assign up_ready = !a_valid_ff || a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (up_ready) begin
         a_valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         a_word_ff <= a_word_in;
      end
   end

   // stage B: hue numerator folded into one turn, divisors, saturation numerator
   always_comb begin
      case (a_word_ff.sector)
         SECT_RED:   base = '0;
         SECT_GREEN: base = {1'b0, a_word_ff.delta, 1'b0};
         SECT_BLUE:  base = {a_word_ff.delta, 2'b00};
         default:    base = '0;
      endcase
      x       = {2'b00, base} + {{3{a_word_ff.diff[COMP_BITS]}}, a_word_ff.diff};
      six_d   = {1'b0, a_word_ff.delta, 2'b00} + {2'b00, a_word_ff.delta, 1'b0};
      // a negative numerator plus one turn always lands below 6*delta
      x_wrap  = x[HREM_BITS-1:0] + six_d;
      sat_num = {a_word_ff.delta, {COMP_BITS{1'b0}}} - {{COMP_BITS{1'b0}}, a_word_ff.delta};

      b_word_in.grey    = (a_word_ff.delta == '0);
      b_word_in.value   = a_word_ff.value;
      b_word_in.hue_div = six_d;
      b_word_in.hue_rem = x[COMP_BITS+3] ? x_wrap : x[HREM_BITS-1:0];
      b_word_in.hue_q   = '0;
      b_word_in.sat_div = SAT_W'({a_word_ff.value, {(SQ_BITS-1){1'b0}}});
      b_word_in.sat_rem = SAT_W'(sat_num);
      b_word_in.sat_q   = '0;
   end

   assign a_ready = !b_valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (a_ready && a_valid_ff) begin
         b_word_ff <= b_word_in;
      end
   end

   assign down_valid = b_valid_ff;
   assign down_word  = b_word_ff;

endmodule

>>> design/rgbhsv_div_stage.sv
// One restoring-divider stage: HUE_STEP hue fraction bits and SAT_STEP saturation bits per word.
// Depends on rgbhsv_pkg.
module rgbhsv_div_stage
   import rgbhsv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  div_word_type up_word,
   output logic         down_valid,
   input  logic         down_ready,
   output div_word_type down_word
);

   logic         valid_ff;
   div_word_type word_ff;
   div_word_type word_in;

   logic [HREM_BITS:0] trial;

   always_comb begin
      word_in = up_word;
      trial   = '0;
      for (int k = 0; k < HUE_STEP; k++) begin
         trial = {word_in.hue_rem, 1'b0};
         if (trial >= {1'b0, word_in.hue_div}) begin
            trial         = trial - {1'b0, word_in.hue_div};
            word_in.hue_q = {word_in.hue_q[HQ_BITS-2:0], 1'b1};
         end else begin
            word_in.hue_q = {word_in.hue_q[HQ_BITS-2:0], 1'b0};
         end
         word_in.hue_rem = trial[HREM_BITS-1:0];
      end
      // divisor is pre-shifted; walk it down one bit per quotient bit
      for (int k = 0; k < SAT_STEP; k++) begin
         if (word_in.sat_rem >= word_in.sat_div) begin
            word_in.sat_rem = word_in.sat_rem - word_in.sat_div;
            word_in.sat_q   = {word_in.sat_q[SQ_BITS-2:0], 1'b1};
         end else begin
            word_in.sat_q   = {word_in.sat_q[SQ_BITS-2:0], 1'b0};
         end
         word_in.sat_div = word_in.sat_div >> 1;
      end
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule
